// ===== rtl/temporal_median_select_defines.svh =====
// temporal_median_select_defines.svh: assertion macros for the median selector checks
// no dependencies; included by the checker file
`ifndef TEMPORAL_MEDIAN_SELECT_DEFINES_SVH
`define TEMPORAL_MEDIAN_SELECT_DEFINES_SVH

// concurrent check, inactive while reset is asserted
`define TMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also holds during reset
`define TMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tms_pkg.sv =====
// tms_pkg: widths shared by the temporal median selector and its checker
// no dependencies
package tms_pkg;

  // fixed field widths of the transaction payloads
  localparam int SampleW    = 8;
  localparam int CountUsedW = 6;

endpackage

// ===== rtl/tms_ram.sv =====
// tms_ram: generic single write port, single read port RAM with registered read
// no dependencies
module tms_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/temporal_median_select.sv =====
// temporal_median_select: per-pixel temporal median over up to MaxSamples frame samples
// depends on tms_pkg and tms_ram
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one 8-bit sample per frame for the
//   current pixel; last_i marks the final sample of the pixel's set. Samples beyond
//   MaxSamples are dropped and reported through overflow_o.
//   Output channel (out_valid_o / out_ready_i) carries one transaction per set: the value
//   of rank floor(n/2) in ascending order (upper median for even n), n and the overflow flag.
// Throughput and latency
//   Samples not marked last are taken one per cycle and written straight into the RAM.
//   After the last sample the block selects the median one bit at a time, from the MSB
//   down: each of the 8 passes reads all n stored samples through the single RAM read
//   port. The result is registered once the selection is done and the output is free;
//   in_ready_o is low from the last sample's acceptance until the result is loaded.
// Reset and stall
//   Reset empties the set and drops any pending result; the RAM contents are not cleared
//   and need not be. A stalled output holds its transaction; further samples of the next
//   pixel are still accepted, and a new result waits until the old one is taken.
module temporal_median_select #(
  parameter int MaxSamples = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tms_pkg::SampleW-1:0]    sample_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tms_pkg::SampleW-1:0]    median_o,
  output logic [tms_pkg::CountUsedW-1:0] count_used_o,
  output logic                           overflow_o
);

  localparam int AddrW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int CntW  = $clog2(MaxSamples + 1);
  localparam int BitW  = $clog2(tms_pkg::SampleW);

  typedef enum logic [1:0] {
    StCollect,
    StScan,
    StDone
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               count_q;
  logic                          ovf_q;
  logic [CntW-1:0]               k_q;
  logic [CntW-1:0]               zeros_q;
  logic [BitW-1:0]               bit_q;
  logic [tms_pkg::SampleW-1:0]   prefix_q;
  logic [AddrW-1:0]              addr_q;
  logic                          issuing_q;
  logic                          rvalid_q;
  logic                          rlast_q;
  logic                          out_valid_q;
  logic [tms_pkg::SampleW-1:0]   median_q;
  logic [tms_pkg::CountUsedW-1:0] count_used_q;
  logic                          overflow_q;

  logic                          in_fire;
  logic                          has_room;
  logic [CntW-1:0]               count_inc;
  logic                          we;
  logic [tms_pkg::SampleW-1:0]   rdata;
  logic                          addr_end;
  logic [tms_pkg::SampleW-1:0]   hi_mask;
  logic                          zero_hit;
  logic [CntW-1:0]               zsum;
  logic                          take_one;
  logic [tms_pkg::SampleW-1:0]   prefix_next;
  logic                          out_free;
  logic [tms_pkg::CountUsedW-1:0] count_ext;

  // input side
  assign in_ready_o = (state_q == StCollect);
  assign in_fire    = in_valid_i && in_ready_o;
  assign has_room   = (count_q < CntW'(MaxSamples));
  assign count_inc  = count_q + CntW'(1);
  assign we         = in_fire && has_room;

  // sample store
  tms_ram #(
    .Width(tms_pkg::SampleW),
    .Depth(MaxSamples)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(sample_i),
    .re_i   (issuing_q),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // one bit of the radix selection per pass
  assign addr_end = (CntW'(addr_q) == count_q - CntW'(1));
  assign hi_mask  = ~(8'hFF >> (3'(tms_pkg::SampleW - 1) - bit_q));
  assign zero_hit = ((rdata & hi_mask) == (prefix_q & hi_mask)) && !rdata[bit_q];
  assign zsum     = zeros_q + CntW'(zero_hit);
  assign take_one = !(k_q < zsum);

  always_comb begin
    prefix_next         = prefix_q;
    prefix_next[bit_q]  = take_one;
  end

  // count reported modulo the field width
  assign out_free  = !out_valid_q || out_ready_i;
  assign count_ext = tms_pkg::CountUsedW'(count_q);

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StCollect;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      issuing_q    <= 1'b0;
      rvalid_q     <= 1'b0;
      rlast_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
      zeros_q      <= '0;
      bit_q        <= '0;
      prefix_q     <= '0;
      addr_q       <= '0;
      median_q     <= '0;
      count_used_q <= '0;
      overflow_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StCollect: begin
          if (in_fire) begin
            if (has_room) begin
              count_q <= count_inc;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q   <= StScan;
              k_q       <= (has_room ? count_inc : count_q) >> 1;
              zeros_q   <= '0;
              bit_q     <= BitW'(tms_pkg::SampleW - 1);
              prefix_q  <= '0;
              addr_q    <= '0;
              issuing_q <= 1'b1;
            end
          end
        end
        StScan: begin
          if (issuing_q) begin
            addr_q <= addr_q + AddrW'(1);
            if (addr_end) begin
              issuing_q <= 1'b0;
            end
          end
          rvalid_q <= issuing_q;
          rlast_q  <= issuing_q && addr_end;
          if (rvalid_q) begin
            if (rlast_q) begin
              prefix_q <= prefix_next;
              zeros_q  <= '0;
              if (take_one) begin
                k_q <= k_q - zsum;
              end
              if (bit_q == '0) begin
                state_q <= StDone;
              end else begin
                bit_q     <= bit_q - BitW'(1);
                addr_q    <= '0;
                issuing_q <= 1'b1;
              end
            end else begin
              zeros_q <= zsum;
            end
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            median_q     <= prefix_q;
            count_used_q <= count_ext;
            overflow_q   <= ovf_q;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            state_q      <= StCollect;
          end
        end
        default: begin
          state_q <= StCollect;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign median_o     = median_q;
  assign count_used_o = count_used_q;
  assign overflow_o   = overflow_q;

endmodule

// ===== rtl/tms_checker.sv =====
// tms_checker: port-level checks on temporal_median_select, bound to the top level
// depends on tms_pkg and temporal_median_select_defines.svh
`include "temporal_median_select_defines.svh"

module tms_checker #(
  parameter int MaxSamples = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [tms_pkg::SampleW-1:0]    sample_i,
  input logic                           last_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [tms_pkg::SampleW-1:0]    median_o,
  input logic [tms_pkg::CountUsedW-1:0] count_used_o,
  input logic                           overflow_o
);

  // no result is shown while in reset
  `TMS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

  // a stalled result transaction stays offered
  `TMS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // closing a set starts the selection, so no sample is taken in the next cycle
  `TMS_ASSERT(a_busy_after_last, clk_i, rst_ni, in_valid_i && in_ready_o && last_i |=> !in_ready_o, "sample taken during selection")

  // an overflowed set always reports a full buffer
  `TMS_ASSERT(a_ovf_full, clk_i, rst_ni, out_valid_o && overflow_o |-> count_used_o == tms_pkg::CountUsedW'(MaxSamples), "overflow without full count")

endmodule

bind temporal_median_select tms_checker #(.MaxSamples(MaxSamples)) u_tms_checker (.*);

// ===== verif/tb_temporal_median_select.sv =====
// tb_temporal_median_select: self-checking bench for the temporal median selector
// depends on tms_pkg and the temporal_median_select rtl; a scoreboard class predicts each
// transaction, tasks drive frame-sample sets with random gaps, a receiver stalls the output
module tb_temporal_median_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSamples    = 32;
  localparam int ItemTarget    = 1600;
  localparam int HoldOffCycles = 800;
  // drain margin sized from the select time of a full set after its last sample
  localparam int DrainCycles   = 8 * (MaxSamples + 1) + 16;
  localparam int WatchdogLimit = 20000;

  typedef logic [tms_pkg::SampleW-1:0]    sample_t;
  typedef logic [tms_pkg::CountUsedW-1:0] count_t;

  typedef struct packed {
    sample_t median;
    count_t  count_used;
    logic    overflow;
  } median_result_t;

  // per-pixel median predictor and the queue of results still owed by the block
  class median_scoreboard;
    sample_t        frame_samples[MaxSamples];
    int unsigned    stored;
    bit             dropped;
    median_result_t owed_q[$];
    int unsigned    errors;

    function new();
      stored  = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    // note an accepted sample; a last-marked one closes the set and owes a result
    function void note_sample(sample_t s, logic is_last);
      sample_t        sorted_a[];
      median_result_t r;
      if (stored < MaxSamples) begin
        frame_samples[stored] = s;
        stored++;
      end else begin
        dropped = 1;
      end
      if (is_last) begin
        sorted_a = new[stored];
        for (int i = 0; i < stored; i++) sorted_a[i] = frame_samples[i];
        sorted_a.sort();
        r.median     = sorted_a[stored / 2];
        r.count_used = stored[tms_pkg::CountUsedW-1:0];
        r.overflow   = dropped;
        owed_q.insert(owed_q.size(), r);
        stored  = 0;
        dropped = 0;
      end
    endfunction

    // compare an accepted result against the oldest one owed
    function void check_result(sample_t med, count_t cnt, logic ovf);
      median_result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result median %0d count_used %0d overflow %0d",
                 $time, med, cnt, ovf);
        errors++;
      end else begin
        exp_r = owed_q.pop_front();
        if (exp_r.median !== med) begin
          $display("%0t: median expected %0d got %0d", $time, exp_r.median, med);
          errors++;
        end
        if (exp_r.count_used !== cnt) begin
          $display("%0t: count_used expected %0d got %0d", $time, exp_r.count_used, cnt);
          errors++;
        end
        if (exp_r.overflow !== ovf) begin
          $display("%0t: overflow expected %0d got %0d", $time, exp_r.overflow, ovf);
          errors++;
        end
      end
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  sample_t sample_i;
  logic    last_i;
  logic    out_valid_o;
  logic    out_ready_i;
  sample_t median_o;
  count_t  count_used_o;
  logic    overflow_o;

  median_scoreboard sb;
  bit               calm;
  bit               hold_req;
  int unsigned      items_sent;
  int unsigned      quiet_cycles;

  temporal_median_select #(
    .MaxSamples(MaxSamples)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_o    (median_o),
    .count_used_o(count_used_o),
    .overflow_o  (overflow_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // monitors and watchdog on quiet cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i, last_i);
      if (out_valid_o && out_ready_i) sb.check_result(median_o, count_used_o, overflow_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result receiver: random stalls, a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_req = 0;
      end
      out_ready_i <= calm || ($urandom_range(99) >= 15);
    end
  end

  // offer one sample and hold it until the transaction completes; called at a falling edge
  task automatic send_sample(sample_t s, logic is_last);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // one pixel set of len samples with random content in a chosen value style
  task automatic send_set(int len);
    int      style;
    sample_t base;
    sample_t s;
    style = $urandom_range(3);
    base  = sample_t'($urandom_range(252));
    for (int i = 0; i < len; i++) begin
      case (style)
        1: s = base + sample_t'($urandom_range(3));   // narrow band, many ties
        2: s = $urandom_range(1) ? 8'hFF : 8'h00;       // extremes only
        default: s = sample_t'($urandom_range(255));
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(31, 9);
    return $urandom_range(MaxSamples + 8, MaxSamples);
  endfunction

  initial begin
    sb           = new();
    rst_ni       = 1'b1;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    last_i       = 1'b0;
    calm         = 0;
    hold_req     = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    // falling edge just after start so the asynchronous reset is seen
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: single samples at both extremes
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b1);
    // even count takes the upper median
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    // ties
    send_sample(8'd9, 1'b0);
    send_sample(8'd9, 1'b0);
    send_sample(8'd3, 1'b1);
    // unordered arrival
    send_sample(8'd200, 1'b0);
    send_sample(8'd17, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd255, 1'b1);
    // all equal
    repeat (4) send_sample(8'd85, 1'b0);
    send_sample(8'd85, 1'b1);
    // alternating bit patterns
    send_sample(8'd170, 1'b0);
    send_sample(8'd85, 1'b0);
    send_sample(8'd255, 1'b1);

    // buffer exactly full, one over, well over (last sample dropped too)
    send_set(MaxSamples);
    send_set(MaxSamples + 1);
    send_set(MaxSamples + 8);

    // random sets, with a receiver hold-off and a stretch with no idling
    while (items_sent < ItemTarget) begin
      // window as wide as the longest set, so it cannot be stepped over
      if (items_sent >= 300 && items_sent < 300 + MaxSamples + 8) hold_req = 1;
      calm = (items_sent >= 800 && items_sent < 1100);
      send_set(pick_len());
    end
    calm = 0;
    in_valid_i <= 1'b0;

    // drain
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
